[rtl/ars_pkg.sv]
// Shared types and constants for the aligned request splitter.
`timescale 1ns / 1ps

package ars_pkg;

	localparam int ADDR_W        = 64;
	localparam int BYTES_W       = 7;
	localparam int OFFS_W        = 6;
	localparam int CFG_IDX_W     = 2;
	localparam int LOW_W         = 7;

	localparam logic [BYTES_W-1:0] MAX_REQ_BYTES = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ALIGN = 2'd1;

	localparam logic [BYTES_W-1:0] OUT_WIDTH_RST = 7'd4;
	localparam logic [BYTES_W-1:0] OUT_ALIGN_RST = 7'd4;

	// Settings seen by the datapath
	typedef struct packed {
		logic [BYTES_W-1:0] width;
		logic [LOW_W-1:0]   mask;
	} cfg_t;

	// One step of the chunk unit
	typedef struct packed {
		logic [BYTES_W-1:0] bytes;
		logic [BYTES_W-1:0] rem_next;
		logic [ADDR_W-1:0]  addr_next;
		logic               last;
	} chunk_res_t;

endpackage

[rtl/ars_cfg_regs.sv]
// Configuration registers: output width and alignment window.
`timescale 1ns / 1ps

module ars_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ars_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ars_pkg::BYTES_W-1:0]    wr_data,
	output ars_pkg::cfg_t                  cfg
);

	logic [ars_pkg::BYTES_W-1:0] width_q;
	logic [ars_pkg::BYTES_W-1:0] align_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= ars_pkg::OUT_WIDTH_RST;
			align_q <= ars_pkg::OUT_ALIGN_RST;
		end else if (wr_en) begin
			case (wr_index)
				ars_pkg::REG_OUT_WIDTH: width_q <= wr_data;
				ars_pkg::REG_OUT_ALIGN: align_q <= wr_data;
				default: ;
			endcase
		end
	end

	// zero alignment behaves as one byte, i.e. no mask bits
	always_comb begin
		cfg.width = width_q;
		cfg.mask  = (align_q == '0) ? '0 : ars_pkg::LOW_W'(align_q - 7'd1);
	end

endmodule

[rtl/ars_chunk_unit.sv]
// Shared chunk unit: size of the next chunk, next address and remaining count.
`timescale 1ns / 1ps

module ars_chunk_unit (
	input  logic [ars_pkg::ADDR_W-1:0]  addr,
	input  logic [ars_pkg::BYTES_W-1:0] rem,
	input  logic                        fwd,
	input  ars_pkg::cfg_t               cfg,
	output ars_pkg::chunk_res_t         res
);

	logic [ars_pkg::LOW_W-1:0]   mis;
	logic [ars_pkg::BYTES_W-1:0] raw;
	logic [ars_pkg::BYTES_W-1:0] bytes;

	always_comb begin
		mis = addr[ars_pkg::LOW_W-1:0] & cfg.mask;
		// width not above misalignment still moves one byte
		raw = (cfg.width > mis) ? ars_pkg::BYTES_W'(cfg.width - mis) : 7'd1;
		if (fwd)
			bytes = rem;
		else
			bytes = (raw > rem) ? rem : raw;
		res.bytes     = bytes;
		res.rem_next  = rem - bytes;
		res.last      = (rem == bytes);
		res.addr_next = addr + ars_pkg::ADDR_W'(bytes);
	end

endmodule

[rtl/aligned_request_splitter.sv]
// Top level: accepts a request and issues its bus chunks one per cycle.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. If its first and last
// byte share one aligned window it comes out as a single chunk with forwarded
// set; otherwise it is cut into chunks in ascending address order. Chunks
// appear one per cycle on the registered result ports, each marked by strobe
// for exactly one cycle, the final one with last_chunk set; the receiver
// cannot stall. A request keeps busy high until its last chunk is issued; a
// zero-length request produces nothing and leaves busy low. The single chunk
// unit handles one chunk per cycle and so sets the pace. Configuration writes
// are always ready; the user must make them only while the block is idle, as
// the block itself does not enforce this.
module aligned_request_splitter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ars_pkg::ADDR_W-1:0]     req_address,
	input  logic [ars_pkg::BYTES_W-1:0]    req_bytes,
	input  logic                           req_write,
	output logic                           strobe,
	output logic [ars_pkg::ADDR_W-1:0]     chunk_address,
	output logic [ars_pkg::BYTES_W-1:0]    chunk_bytes,
	output logic [ars_pkg::OFFS_W-1:0]     data_offset,
	output logic                           chunk_write,
	output logic                           forwarded,
	output logic                           last_chunk,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ars_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ars_pkg::BYTES_W-1:0]    cfg_data
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                      state_q;
	logic [ars_pkg::ADDR_W-1:0]  addr_q;
	logic [ars_pkg::BYTES_W-1:0] rem_q;
	logic [ars_pkg::OFFS_W-1:0]  offs_q;
	logic                        wr_q;
	logic                        fwd_q;

	ars_pkg::cfg_t               cfg;
	ars_pkg::chunk_res_t         res;

	logic                        accept;
	logic [ars_pkg::BYTES_W-1:0] size_sat;
	logic [ars_pkg::LOW_W:0]     end_low;
	logic                        fwd_in;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;

	ars_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ars_chunk_unit u_chunk (
		.addr (addr_q),
		.rem  (rem_q),
		.fwd  (fwd_q),
		.cfg  (cfg),
		.res  (res)
	);

	// Window check on the low bits: a carry out of them always changes the
	// upper address bits, so only the masked low bits need comparing otherwise.
	always_comb begin
		size_sat = (req_bytes > ars_pkg::MAX_REQ_BYTES) ? ars_pkg::MAX_REQ_BYTES : req_bytes;
		end_low  = {1'b0, req_address[ars_pkg::LOW_W-1:0]}
		         + {1'b0, ars_pkg::LOW_W'(size_sat - 7'd1)};
		fwd_in   = !end_low[ars_pkg::LOW_W]
		        && ((req_address[ars_pkg::LOW_W-1:0] & ~cfg.mask)
		            == (end_low[ars_pkg::LOW_W-1:0] & ~cfg.mask));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && req_bytes != '0)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					strobe <= 1'b1;
					if (res.last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			addr_q <= req_address;
			rem_q  <= size_sat;
			offs_q <= '0;
			wr_q   <= req_write;
			fwd_q  <= fwd_in;
		end else begin
			addr_q <= res.addr_next;
			rem_q  <= res.rem_next;
			offs_q <= offs_q + ars_pkg::OFFS_W'(res.bytes);
		end
		if (state_q == ST_RUN) begin
			chunk_address <= addr_q;
			chunk_bytes   <= res.bytes;
			data_offset   <= offs_q;
			chunk_write   <= wr_q;
			forwarded     <= fwd_q;
			last_chunk    <= res.last;
		end
	end

	a_strobe_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("chunk issued without a request in progress");

	a_chunks_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_chunk |=> strobe)
		else $error("gap between chunks of one request");

	a_forward_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && forwarded |-> last_chunk && data_offset == '0)
		else $error("forwarded transfer not a single chunk");

	a_addr_advance: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_chunk |=>
		chunk_address == ars_pkg::ADDR_W'($past(chunk_address)
		                 + ars_pkg::ADDR_W'($past(chunk_bytes))))
		else $error("chunk address does not follow previous chunk");

endmodule
